// File: hdl/crc64we_pkg.sv
// ----------------------------------------------------------------------------
// crc64we_pkg
// Types, constants and functions shared by the CRC-64 word engine.
// ----------------------------------------------------------------------------
package crc64we_pkg;

  localparam int unsigned CrcWidth   = 64;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned BusWidth   = 64;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned StepBytes  = 8;
  localparam int unsigned FeedWidth  = 2 * CrcWidth;

  localparam logic [CrcWidth-1:0] CrcFeedback = 64'h0000_0000_0000_001B;

  // Register index, taken from paddr[3] (registers are 8 bytes apart).
  localparam logic RegInitValue = 1'b0;

  typedef struct packed {
    logic [CrcWidth-1:0] data_word;
    logic                restart;
  } in_item_t;

  typedef struct packed {
    logic [CrcWidth-1:0]   crc_value;
    logic [CountWidth-1:0] byte_count;
    logic [31:0]           header_crc_high;
    logic [31:0]           header_crc_low;
    logic [31:0]           header_length;
  } out_item_t;

  typedef logic [CrcWidth-1:0][FeedWidth-1:0] crc_matrix_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // Bit-serial reference update, MSB of the data first.
  function automatic logic [CrcWidth-1:0] crc_serial(input logic [CrcWidth-1:0] crc_in,
                                                     input logic [CrcWidth-1:0] data);
    logic [CrcWidth-1:0] crc;
    logic                fb;
    crc = crc_in;
    for (int i = CrcWidth - 1; i >= 0; i--) begin
      fb  = crc[CrcWidth-1] ^ data[i];
      crc = {crc[CrcWidth-2:0], 1'b0} ^ (fb ? CrcFeedback : '0);
    end
    return crc;
  endfunction

  // The update is linear over {crc, data}. Row j lists which of those 128 bits
  // feed CRC bit j. Data bits sit in [63:0], CRC bits in [127:64].
  function automatic crc_matrix_t crc_matrix();
    crc_matrix_t         m;
    logic [CrcWidth-1:0] col;
    logic [CrcWidth-1:0] basis;
    m = '0;
    for (int k = 0; k < FeedWidth; k++) begin
      basis = '0;
      basis[k % CrcWidth] = 1'b1;
      if (k < CrcWidth) begin
        col = crc_serial('0, basis);
      end else begin
        col = crc_serial(basis, '0);
      end
      for (int j = 0; j < CrcWidth; j++) begin
        m[j][k] = col[j];
      end
    end
    return m;
  endfunction

  localparam crc_matrix_t CrcMatrix = crc_matrix();

endpackage

// File: hdl/crc64_word_engine_core.sv
// ----------------------------------------------------------------------------
// crc64_word_engine_core
// CRC-64 engine over 64-bit firmware words with header word packing.
// ----------------------------------------------------------------------------
// An accepted item is held in in_q, then moves into the result register.
// One item per cycle when not stalled; the parallel XOR update covers a whole word.
// The result register also holds the running CRC and byte count.
// Reset (rst, synchronous) clears the CRC, the count, init_value and both
// valid flags.
module crc64_word_engine_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  crc64we_pkg::in_item_t                in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output crc64we_pkg::out_item_t               out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [crc64we_pkg::AddrWidth-1:0]    paddr,
  input  logic [crc64we_pkg::BusWidth-1:0]     pwdata,
  output logic [crc64we_pkg::BusWidth-1:0]     prdata,
  output logic                                 pready
);

  logic [crc64we_pkg::CrcWidth-1:0] init_value;
  crc64we_pkg::in_item_t            in_q;
  logic                             in_q_valid;
  crc64we_pkg::out_item_t           result;
  crc64we_pkg::out_item_t           result_next;
  logic                             result_valid;
  logic                             move;

  crc64we_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .init_value (init_value)
  );

  crc64we_update u_update (
    .item       (in_q),
    .crc_cur    (result.crc_value),
    .count_cur  (result.byte_count),
    .init_value (init_value),
    .result     (result_next)
  );

  // The held item moves on when the result register is empty or being drained.
  assign move     = in_q_valid && (!result_valid || out_ready);
  assign in_ready = !in_q_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      if (move) begin
        result_valid <= 1'b1;
        result       <= result_next;
      end else if (out_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign out_valid = result_valid;
  assign out_data  = result;

  a_move_fills: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("result register not loaded after item moved");

  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    move && in_q.restart |=> out_data.byte_count == 32'd8)
    else $error("byte count not restarted");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    move && !in_q.restart |=> out_data.byte_count == $past(out_data.byte_count) + 32'd8)
    else $error("byte count did not advance by one word");

  a_header_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.header_length == crc64we_pkg::swap32(out_data.byte_count))
    else $error("header length does not match byte count");

endmodule

// File: hdl/crc64we_regs.sv
// ----------------------------------------------------------------------------
// crc64we_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module crc64we_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [crc64we_pkg::AddrWidth-1:0]    paddr,
  input  logic [crc64we_pkg::BusWidth-1:0]     pwdata,
  output logic [crc64we_pkg::BusWidth-1:0]     prdata,
  output logic                                 pready,
  output logic [crc64we_pkg::CrcWidth-1:0]     init_value
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[crc64we_pkg::AddrWidth-1];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= '0;
    end else if (wr_en && reg_index == crc64we_pkg::RegInitValue) begin
      init_value <= pwdata;
    end
  end

  always_comb begin
    case (reg_index)
      crc64we_pkg::RegInitValue: prdata = init_value;
      default:                   prdata = '0;
    endcase
  end

endmodule

// File: hdl/crc64we_update.sv
// ----------------------------------------------------------------------------
// crc64we_update
// One-word parallel CRC-64 update, byte count and header packing.
// ----------------------------------------------------------------------------
module crc64we_update (
  input  crc64we_pkg::in_item_t                  item,
  input  logic [crc64we_pkg::CrcWidth-1:0]       crc_cur,
  input  logic [crc64we_pkg::CountWidth-1:0]     count_cur,
  input  logic [crc64we_pkg::CrcWidth-1:0]       init_value,
  output crc64we_pkg::out_item_t                 result
);

  logic [crc64we_pkg::CrcWidth-1:0]   crc_start;
  logic [crc64we_pkg::CountWidth-1:0] count_start;
  logic [crc64we_pkg::CrcWidth-1:0]   data_swapped;
  logic [crc64we_pkg::FeedWidth-1:0]  feed;
  logic [crc64we_pkg::CrcWidth-1:0]   crc_new;
  logic [crc64we_pkg::CountWidth-1:0] count_new;

  assign crc_start    = item.restart ? init_value : crc_cur;
  assign count_start  = item.restart ? '0 : count_cur;
  assign data_swapped = {crc64we_pkg::swap32(item.data_word[63:32]),
                         crc64we_pkg::swap32(item.data_word[31:0])};
  assign feed         = {crc_start, data_swapped};

  // Each CRC bit is the parity of a fixed subset of the old CRC and the word.
  always_comb begin
    for (int j = 0; j < crc64we_pkg::CrcWidth; j++) begin
      crc_new[j] = ^(feed & crc64we_pkg::CrcMatrix[j]);
    end
  end

  assign count_new = count_start + crc64we_pkg::CountWidth'(crc64we_pkg::StepBytes);

  assign result.crc_value       = crc_new;
  assign result.byte_count      = count_new;
  assign result.header_crc_high = crc64we_pkg::swap32(crc_new[31:0]);
  assign result.header_crc_low  = crc64we_pkg::swap32(crc_new[63:32]);
  assign result.header_length   = crc64we_pkg::swap32(count_new);

endmodule

// File: bench/tb_crc64_word_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crc64_word_engine_core
// Streams firmware words through the CRC-64 word engine with random idle
// cycles and output stalls. A local bit-serial CRC predictor tracks the
// running CRC and byte count, and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_crc64_word_engine_core;

  localparam logic [63:0]          PolyTaps      = 64'h0000_0000_0000_001B;
  localparam logic [31:0]          WordBytes     = 32'd8;
  localparam int unsigned          ResultLatency = 1;
  localparam int unsigned          CycleLimit    = 400_000;
  localparam int unsigned          RandomPhases  = 6;
  localparam int unsigned          PhaseWords    = 115;
  // Registers sit 8 bytes apart; paddr[3] selects the register.
  localparam logic [crc64we_pkg::AddrWidth-1:0] InitAddr   =
    {crc64we_pkg::RegInitValue, 3'b000};
  localparam logic [crc64we_pkg::AddrWidth-1:0] UnusedAddr =
    {~crc64we_pkg::RegInitValue, 3'b000};

  typedef struct packed {
    crc64we_pkg::in_item_t word;
    logic [15:0]           gap;
    logic                  hold;
  } feed_entry_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  crc64we_pkg::in_item_t               in_data = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  crc64we_pkg::out_item_t              out_data;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [crc64we_pkg::AddrWidth-1:0]   paddr = '0;
  logic [crc64we_pkg::BusWidth-1:0]    pwdata = '0;
  logic [crc64we_pkg::BusWidth-1:0]    prdata;
  logic                                pready;

  feed_entry_t            word_feed[$];
  crc64we_pkg::out_item_t expected_sums[$];
  feed_entry_t            cur_feed;
  bit                     cur_loaded = 1'b0;
  int unsigned            idle_left = 0;
  int unsigned            stall_left = 0;
  bit                     source_calm = 1'b0;
  bit                     sink_calm = 1'b0;
  int unsigned            error_count = 0;
  int unsigned            cycle_count = 0;

  // Shadow state of the engine.
  logic [63:0] crc_run = '0;
  logic [31:0] bytes_run = '0;
  logic [63:0] init_run = '0;

  crc64_word_engine_core dut (
    .clk, .rst,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] byte_rev(input logic [31:0] w);
    logic [31:0] r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = w[8*(3-b) +: 8];
    end
    return r;
  endfunction

  // Advances the shadow CRC by one word and returns the result it should give.
  function automatic crc64we_pkg::out_item_t predict_word(input crc64we_pkg::in_item_t w);
    logic [63:0]            msg;
    crc64we_pkg::out_item_t r;
    if (w.restart) begin
      crc_run   = init_run;
      bytes_run = '0;
    end
    // Each 32-bit half is byte-swapped in place, then bit 63 goes in first.
    msg = {byte_rev(w.data_word[63:32]), byte_rev(w.data_word[31:0])};
    for (int i = 63; i >= 0; i--) begin
      if (crc_run[63] ^ msg[i]) begin
        crc_run = {crc_run[62:0], 1'b0} ^ PolyTaps;
      end else begin
        crc_run = {crc_run[62:0], 1'b0};
      end
    end
    bytes_run         = bytes_run + WordBytes;
    r.crc_value       = crc_run;
    r.byte_count      = bytes_run;
    r.header_crc_high = byte_rev(crc_run[31:0]);
    r.header_crc_low  = byte_rev(crc_run[63:32]);
    r.header_length   = byte_rev(bytes_run);
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 49);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic queue_word(input logic [63:0] data, input logic restart, input logic hold);
    feed_entry_t e;
    e.word.data_word = data;
    e.word.restart   = restart;
    e.gap            = source_calm ? 16'd0 : 16'(draw_gap());
    e.hold           = hold;
    word_feed.push_back(e);
  endtask

  task automatic write_reg(input logic [crc64we_pkg::AddrWidth-1:0] addr,
                           input logic [crc64we_pkg::BusWidth-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[3] == crc64we_pkg::RegInitValue) begin
      init_run = value;
    end
  endtask

  // Returns once every queued word has been taken and answered.
  task automatic settle_stream();
    @(negedge clk);
    while (word_feed.size() != 0 || cur_loaded || in_valid || expected_sums.size() != 0) begin
      @(negedge clk);
    end
    repeat (ResultLatency + 2) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Word driver. A word marked hold is not offered until all results are back.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_sums.push_back(predict_word(in_data));
      end
      if (!in_valid || in_ready) begin
        if (!cur_loaded && word_feed.size() != 0) begin
          cur_feed   = word_feed.pop_front();
          cur_loaded = 1'b1;
          idle_left  = 32'(cur_feed.gap);
        end
        if (cur_loaded && idle_left == 0 && !(cur_feed.hold && expected_sums.size() != 0)) begin
          in_valid   <= 1'b1;
          in_data    <= cur_feed.word;
          cur_loaded = 1'b0;
        end else begin
          if (idle_left > 0) idle_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink with random stalls.
  always @(posedge clk) begin
    int unsigned g;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      g = sink_calm ? 0 : draw_gap();
      if (g > 0) begin
        stall_left = g - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    crc64we_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_sums.pop_front();
        check_field("crc_value", want.crc_value, out_data.crc_value);
        check_field("byte_count", want.byte_count, out_data.byte_count);
        check_field("header_crc_high", want.header_crc_high, out_data.header_crc_high);
        check_field("header_crc_low", want.header_crc_low, out_data.header_crc_low);
        check_field("header_length", want.header_length, out_data.header_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL crc64_word_engine_core");
      $finish;
    end
  end

  initial begin
    logic [63:0] seed_val;
    int unsigned hold_at;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words against the reset init value of zero.
    source_calm = 1'b1;
    write_reg(InitAddr, 64'h0);
    queue_word(64'h0, 1'b1, 1'b0);
    queue_word('1, 1'b0, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b0, 1'b0);
    queue_word(64'h0000_0000_0000_0001, 1'b0, 1'b0);
    queue_word(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    queue_word(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0);
    queue_word(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0);
    source_calm = 1'b0;
    queue_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    queue_word(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    settle_stream();

    // A write to a register that does not exist must leave init_value alone.
    write_reg(UnusedAddr, 64'hDEAD_BEEF_CAFE_F00D);
    queue_word(64'h0000_0000_0000_0000, 1'b1, 1'b0);
    queue_word(64'h1122_3344_5566_7788, 1'b0, 1'b0);
    settle_stream();

    // A new init_value only matters at the next restart.
    write_reg(InitAddr, '1);
    queue_word(64'h0, 1'b0, 1'b0);
    queue_word(64'h0, 1'b1, 1'b0);
    queue_word('1, 1'b0, 1'b0);
    queue_word('1, 1'b1, 1'b0);
    settle_stream();

    write_reg(InitAddr, 64'h8000_0000_0000_0001);
    queue_word(64'hFEDC_BA98_7654_3210, 1'b0, 1'b0);
    queue_word(64'hFEDC_BA98_7654_3210, 1'b1, 1'b0);
    queue_word(64'h0000_0001_8000_0000, 1'b0, 1'b0);
    settle_stream();

    // Random images: runs of words between restarts, one phase with no idling.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        1: seed_val = '1;
        3: seed_val = '0;
        default: seed_val = {$urandom, $urandom};
      endcase
      write_reg(InitAddr, seed_val);
      source_calm = (p == 2);
      sink_calm   = (p == 2);
      hold_at     = $urandom_range(10, PhaseWords - 10);
      for (int n = 0; n < PhaseWords; n++) begin
        queue_word(rand_word(), ($urandom_range(0, 11) == 0) || (n == 0 && p[0]),
                   n == hold_at);
      end
      settle_stream();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS crc64_word_engine_core");
    end else begin
      $display("FAIL crc64_word_engine_core");
    end
    $finish;
  end

endmodule

// File: crc64_word_engine_core.f
hdl/crc64we_pkg.sv
hdl/crc64we_regs.sv
hdl/crc64we_update.sv
hdl/crc64_word_engine_core.sv
bench/tb_crc64_word_engine_core.sv
